// ===== rtl/c8x_pkg.sv =====
package c8x_pkg;

  typedef logic [11:0] addr_t;
  typedef logic [7:0]  byte_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_UNSUPP  = 2'd2;

  // ALU operations
  localparam logic [3:0] ALU_MOVY = 4'd0;
  localparam logic [3:0] ALU_OR   = 4'd1;
  localparam logic [3:0] ALU_AND  = 4'd2;
  localparam logic [3:0] ALU_XOR  = 4'd3;
  localparam logic [3:0] ALU_ADD  = 4'd4;
  localparam logic [3:0] ALU_SUB  = 4'd5;
  localparam logic [3:0] ALU_SHR  = 4'd6;
  localparam logic [3:0] ALU_RSB  = 4'd7;
  localparam logic [3:0] ALU_SHL  = 4'd8;
  localparam logic [3:0] ALU_MOVN = 4'd9;
  localparam logic [3:0] ALU_ADDN = 4'd10;

  typedef struct packed {
    logic [3:0] op;
    byte_t      a;
    byte_t      b;
  } alu_req_t;

  typedef struct packed {
    byte_t res;
    logic  flag;
    logic  flag_wr;
    logic  eq;
  } alu_rsp_t;

endpackage

// ===== rtl/c8x_alu.sv =====
module c8x_alu (
  input  c8x_pkg::alu_req_t req,
  output c8x_pkg::alu_rsp_t rsp
);

  logic [8:0] sum;
  logic [8:0] dif;
  logic [8:0] rdif;

  assign sum  = {1'b0, req.a} + {1'b0, req.b};
  assign dif  = {1'b0, req.a} - {1'b0, req.b};
  assign rdif = {1'b0, req.b} - {1'b0, req.a};

  always_comb begin
    rsp.res     = req.b;
    rsp.flag    = 1'b0;
    rsp.flag_wr = 1'b0;
    rsp.eq      = (req.a == req.b);
    unique case (req.op)
      c8x_pkg::ALU_MOVY: rsp.res = req.b;
      c8x_pkg::ALU_OR:   rsp.res = req.a | req.b;
      c8x_pkg::ALU_AND:  rsp.res = req.a & req.b;
      c8x_pkg::ALU_XOR:  rsp.res = req.a ^ req.b;
      c8x_pkg::ALU_ADD: begin
        rsp.res = sum[7:0]; rsp.flag = sum[8]; rsp.flag_wr = 1'b1;
      end
      c8x_pkg::ALU_SUB: begin
        rsp.res = dif[7:0]; rsp.flag = dif[8]; rsp.flag_wr = 1'b1;
      end
      c8x_pkg::ALU_SHR: begin
        rsp.res = {1'b0, req.a[7:1]}; rsp.flag = req.a[0]; rsp.flag_wr = 1'b1;
      end
      c8x_pkg::ALU_RSB: begin
        rsp.res = rdif[7:0]; rsp.flag = rdif[8]; rsp.flag_wr = 1'b1;
      end
      c8x_pkg::ALU_SHL: begin
        rsp.res = {req.a[6:0], 1'b0}; rsp.flag = req.a[7]; rsp.flag_wr = 1'b1;
      end
      c8x_pkg::ALU_MOVN: rsp.res = req.b;
      c8x_pkg::ALU_ADDN: rsp.res = sum[7:0];
      default: rsp.res = req.b;
    endcase
  end

endmodule

// ===== rtl/chip8_instruction_execute_core.sv =====
// Flow: an accepted instruction passes the register read and execute states;
// the execute state registers the first result beat. BCD then runs its
// repeated-subtract digit steps before its three beats; store emits x+1 beats,
// one per cycle while the output is not stalled. One instruction at a time;
// a stalled result beat holds the sequencer.
// Reset: V registers, I, stack pointer cleared; PC loaded with 512.
// Return stack holds no reset value.
module chip8_instruction_execute_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] next_pc,
  output logic        write_valid,
  output logic [11:0] write_address,
  output logic [7:0]  write_data,
  output logic [1:0]  status,
  output logic        last
);

  localparam int SPW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_BCD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_STOR = 3'd5;

  logic [2:0]  state;
  logic [15:0] op;
  logic [7:0]  vreg [16];
  logic [11:0] pc;
  logic [11:0] ireg;
  logic [SPW-1:0] sp;
  logic [11:0] stack [STACK_DEPTH];
  logic [11:0] stack_q;
  logic [7:0]  vx;
  logic [7:0]  vy;
  logic [3:0]  k;
  logic [7:0]  bcd_rem;
  logic [3:0]  bcd_h;
  logic [3:0]  bcd_t;
  logic [1:0]  bcd_step;
  logic [1:0]  bcd_cnt;
  logic [3:0]  bcd_q;

  c8x_pkg::alu_req_t alu_req;
  c8x_pkg::alu_rsp_t alu_rsp;

  c8x_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  logic [3:0] ox, oy, on;
  logic [7:0] nn;
  logic [11:0] nnn;
  assign ox  = op[11:8];
  assign oy  = op[7:4];
  assign on  = op[3:0];
  assign nn  = op[7:0];
  assign nnn = op[11:0];

  assign in_stall = (state != S_IDLE);

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    alu_req.a  = vx;
    alu_req.b  = vy;
    alu_req.op = c8x_pkg::ALU_MOVY;
    unique case (op[15:12])
      4'h3, 4'h4: begin alu_req.b = nn; alu_req.op = c8x_pkg::ALU_MOVN; end
      4'h6:       begin alu_req.b = nn; alu_req.op = c8x_pkg::ALU_MOVN; end
      4'h7:       begin alu_req.b = nn; alu_req.op = c8x_pkg::ALU_ADDN; end
      4'h8:       alu_req.op = (on == 4'hE) ? c8x_pkg::ALU_SHL : on;
      default:    alu_req.op = c8x_pkg::ALU_MOVY;
    endcase
  end

  // decode classification
  logic unknown, unsupp;
  always_comb begin
    unknown = 1'b0;
    unsupp  = 1'b0;
    unique case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) unsupp = 1'b1;
        else if (op != 16'h00EE) unknown = 1'b1;
      end
      4'h5, 4'h9: unknown = (on != 4'h0);
      4'h8: unknown = !(on <= 4'h7 || on == 4'hE);
      4'hC, 4'hD: unsupp = 1'b1;
      4'hE: begin
        if (nn == 8'h9E || nn == 8'hA1) unsupp = 1'b1;
        else unknown = 1'b1;
      end
      4'hF: begin
        if (nn == 8'h07 || nn == 8'h0A || nn == 8'h15 || nn == 8'h18 ||
            nn == 8'h29 || nn == 8'h30 || nn == 8'h65) unsupp = 1'b1;
        else if (!(nn == 8'h1E || nn == 8'h33 || nn == 8'h55)) unknown = 1'b1;
      end
      default: ;
    endcase
  end

  logic [11:0] pc2, pc4;
  assign pc2 = pc + 12'd2;
  assign pc4 = pc + 12'd4;

  // wrap the pointer at the stack depth
  logic [SPW-1:0] sp_dec;
  logic [SPW-1:0] sp_inc;
  assign sp_dec = (sp == '0) ? SPW'(STACK_DEPTH - 1) : sp - 1'b1;
  assign sp_inc = (sp == SPW'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;

  always_ff @(posedge clk) begin
    stack_q <= stack[sp_dec];
    if (state == S_EXEC && op[15:12] == 4'h2 && out_free)
      stack[sp] <= pc2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pc        <= 12'd512;
      ireg      <= '0;
      sp        <= '0;
      for (int i = 0; i < 16; i++) vreg[i] <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) pc <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= instruction;
            state <= S_READ;
          end
        end
        S_READ: begin
          vx    <= vreg[ox];
          vy    <= (op[15:12] == 4'hB) ? vreg[0] : vreg[oy];
          k     <= '0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            next_pc       <= pc2;
            write_valid   <= 1'b0;
            write_address <= '0;
            write_data    <= '0;
            status        <= c8x_pkg::STATUS_OK;
            last          <= 1'b1;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
            if (unknown) begin
              next_pc <= '0; pc <= '0; status <= c8x_pkg::STATUS_UNKNOWN;
            end else if (unsupp) begin
              pc <= pc2; status <= c8x_pkg::STATUS_UNSUPP;
            end else begin
              pc <= pc2;
              priority case (op[15:12])
                4'h0: begin next_pc <= stack_q; pc <= stack_q; sp <= sp_dec; end
                4'h1: begin next_pc <= nnn; pc <= nnn; end
                4'h2: begin next_pc <= nnn; pc <= nnn; sp <= sp_inc; end
                4'h3, 4'h5: if (alu_rsp.eq) begin next_pc <= pc4; pc <= pc4; end
                4'h4, 4'h9: if (!alu_rsp.eq) begin next_pc <= pc4; pc <= pc4; end
                4'h6, 4'h7, 4'h8: begin
                  vreg[ox] <= alu_rsp.res;
                  if (alu_rsp.flag_wr) vreg[15] <= {7'd0, alu_rsp.flag};
                end
                4'hA: ireg <= nnn;
                4'hB: begin
                  next_pc <= nnn + {4'd0, vy}; pc <= nnn + {4'd0, vy};
                end
                default: begin
                  if (nn == 8'h1E) ireg <= ireg + {4'd0, vx};
                  else if (nn == 8'h33) begin
                    out_valid <= 1'b0;
                    bcd_rem   <= vx;
                    bcd_h     <= '0;
                    bcd_t     <= '0;
                    bcd_step  <= 2'd0;
                    state     <= S_BCD;
                  end else begin
                    out_valid <= 1'b0;
                    state     <= S_STOR;
                  end
                end
              endcase
            end
          end
        end
        S_BCD: begin
          // repeated subtract: hundreds then tens
          if (bcd_step == 2'd0) begin
            if (bcd_rem >= 8'd100) begin
              bcd_rem <= bcd_rem - 8'd100; bcd_h <= bcd_h + 1'b1;
            end else bcd_step <= 2'd1;
          end else begin
            if (bcd_rem >= 8'd10) begin
              bcd_rem <= bcd_rem - 8'd10; bcd_t <= bcd_t + 1'b1;
            end else begin
              bcd_cnt <= 2'd0;
              state   <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            next_pc       <= pc;
            write_valid   <= 1'b1;
            write_address <= ireg + {10'd0, bcd_cnt};
            write_data    <= {4'd0, bcd_q};
            status        <= c8x_pkg::STATUS_OK;
            last          <= (bcd_cnt == 2'd2);
            out_valid     <= 1'b1;
            bcd_cnt       <= bcd_cnt + 1'b1;
            if (bcd_cnt == 2'd2) state <= S_IDLE;
          end
        end
        S_STOR: begin
          if (out_free) begin
            next_pc       <= pc;
            write_valid   <= 1'b1;
            write_address <= ireg + {8'd0, k};
            write_data    <= vreg[k];
            status        <= c8x_pkg::STATUS_OK;
            last          <= (k == ox);
            out_valid     <= 1'b1;
            k             <= k + 1'b1;
            if (k == ox) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (bcd_cnt)
      2'd0:    bcd_q = bcd_h;
      2'd1:    bcd_q = bcd_t;
      default: bcd_q = bcd_rem[3:0];
    endcase
  end

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall)
    else $error("accept while busy");
  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> bcd_h <= 4'd2 && bcd_t <= 4'd9 && bcd_rem <= 8'd9)
    else $error("bcd digit out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({next_pc, write_valid, write_address, write_data, status, last}))
    else $error("stalled beat changed");

endmodule

// ===== test/chip8_checker.sv =====
module chip8_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] instruction,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] next_pc,
  input  logic        write_valid,
  input  logic [11:0] write_address,
  input  logic [7:0]  write_data,
  input  logic [1:0]  status,
  input  logic        last,
  output int          errors,
  output int          pending
);

  // opcode groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEN  = 4'h3;
  localparam logic [3:0] GRP_SNEN = 4'h4;
  localparam logic [3:0] GRP_SEY  = 4'h5;
  localparam logic [3:0] GRP_LDN  = 4'h6;
  localparam logic [3:0] GRP_ADDN = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNEY = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] SUB_SHL  = 4'hE;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;
  localparam logic [7:0]  KEY_SKP = 8'h9E;
  localparam logic [7:0]  KEY_SKNP = 8'hA1;
  localparam logic [7:0]  MISC_ADDI = 8'h1E;
  localparam logic [7:0]  MISC_BCD = 8'h33;
  localparam logic [7:0]  MISC_STORE = 8'h55;

  typedef struct {
    c8x_pkg::addr_t pc;
    logic           wv;
    c8x_pkg::addr_t addr;
    c8x_pkg::byte_t data;
    logic [1:0]     st;
    logic           lst;
  } beat_t;

  beat_t  expected_beats[$];
  c8x_pkg::byte_t vreg[16];
  c8x_pkg::addr_t pc_q;
  c8x_pkg::addr_t index_q;
  c8x_pkg::addr_t ret_stack[16];
  logic [3:0] sp_q;
  c8x_pkg::addr_t start_q;

  assign pending = expected_beats.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic push_beat(input c8x_pkg::addr_t pc, input logic wv,
                           input c8x_pkg::addr_t a, input c8x_pkg::byte_t d,
                           input logic [1:0] st, input logic lst);
    beat_t b;
    b.pc = pc; b.wv = wv; b.addr = a; b.data = d; b.st = st; b.lst = lst;
    expected_beats.push_back(b);
  endtask

  task automatic execute_opcode(input logic [15:0] w);
    logic [3:0] x, y, n;
    c8x_pkg::byte_t nn, vx, vy;
    c8x_pkg::addr_t nnn, nxt;
    logic [1:0] st;
    logic bad;
    logic [8:0] sum;
    int cnt;
    c8x_pkg::addr_t wa[16];
    c8x_pkg::byte_t wd[16];
    x = w[11:8]; y = w[7:4]; n = w[3:0]; nn = w[7:0]; nnn = w[11:0];
    vx = vreg[x]; vy = vreg[y];
    nxt = pc_q + 12'd2;
    st = c8x_pkg::STATUS_OK;
    bad = 1'b0;
    cnt = 0;
    case (w[15:12])
      GRP_SYS: begin
        if (w == OPC_CLS) st = c8x_pkg::STATUS_UNSUPP;
        else if (w == OPC_RET) begin
          sp_q = sp_q - 4'd1;
          nxt = ret_stack[sp_q];
        end else bad = 1'b1;
      end
      GRP_JP: nxt = nnn;
      GRP_CALL: begin
        ret_stack[sp_q] = pc_q + 12'd2;
        sp_q = sp_q + 4'd1;
        nxt = nnn;
      end
      GRP_SEN:  if (vx == nn) nxt = pc_q + 12'd4;
      GRP_SNEN: if (vx != nn) nxt = pc_q + 12'd4;
      GRP_SEY: begin
        if (n != 4'd0) bad = 1'b1;
        else if (vx == vy) nxt = pc_q + 12'd4;
      end
      GRP_LDN:  vreg[x] = nn;
      GRP_ADDN: vreg[x] = vx + nn;
      GRP_ALU: begin
        case (n)
          c8x_pkg::ALU_MOVY: vreg[x] = vy;
          c8x_pkg::ALU_OR:   vreg[x] = vx | vy;
          c8x_pkg::ALU_AND:  vreg[x] = vx & vy;
          c8x_pkg::ALU_XOR:  vreg[x] = vx ^ vy;
          c8x_pkg::ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            vreg[x] = sum[7:0];
            vreg[15] = {7'd0, sum[8]};
          end
          c8x_pkg::ALU_SUB: begin
            vreg[x] = vx - vy;
            vreg[15] = {7'd0, vx < vy};
          end
          c8x_pkg::ALU_SHR: begin
            vreg[x] = vx >> 1;
            vreg[15] = {7'd0, vx[0]};
          end
          c8x_pkg::ALU_RSB: begin
            vreg[x] = vy - vx;
            vreg[15] = {7'd0, vy < vx};
          end
          SUB_SHL: begin
            vreg[x] = vx << 1;
            vreg[15] = {7'd0, vx[7]};
          end
          default: bad = 1'b1;
        endcase
      end
      GRP_SNEY: begin
        if (n != 4'd0) bad = 1'b1;
        else if (vx != vy) nxt = pc_q + 12'd4;
      end
      GRP_LDI:  index_q = nnn;
      GRP_JPV0: nxt = nnn + {4'd0, vreg[0]};
      GRP_RND, GRP_DRW: st = c8x_pkg::STATUS_UNSUPP;
      GRP_KEY: begin
        if (nn == KEY_SKP || nn == KEY_SKNP) st = c8x_pkg::STATUS_UNSUPP;
        else bad = 1'b1;
      end
      default: begin
        case (nn)
          8'h07, 8'h0A, 8'h15, 8'h18, 8'h29, 8'h30, 8'h65: st = c8x_pkg::STATUS_UNSUPP;
          MISC_ADDI: index_q = index_q + {4'd0, vx};
          MISC_BCD: begin
            for (int k = 0; k < 3; k++) wa[k] = index_q + 12'(k);
            wd[0] = vx / 8'd100;
            wd[1] = (vx / 8'd10) % 8'd10;
            wd[2] = vx % 8'd10;
            cnt = 3;
          end
          MISC_STORE: begin
            for (int k = 0; k <= x; k++) begin
              wa[k] = index_q + 12'(k);
              wd[k] = vreg[k];
            end
            cnt = x + 1;
          end
          default: bad = 1'b1;
        endcase
      end
    endcase
    if (bad) begin
      nxt = '0;
      st = c8x_pkg::STATUS_UNKNOWN;
      cnt = 0;
    end
    pc_q = nxt;
    if (cnt == 0) push_beat(nxt, 1'b0, '0, '0, st, 1'b1);
    for (int k = 0; k < cnt; k++) push_beat(nxt, 1'b1, wa[k], wd[k], st, k == cnt - 1);
  endtask

  initial errors = 0;

  // sample between edges: inputs change only at the rising edge
  always @(negedge clk) begin
    beat_t e;
    if (rst) begin
      foreach (vreg[i]) vreg[i] = '0;
      start_q = 12'd512;
      pc_q = start_q;
      index_q = '0;
      sp_q = '0;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        start_q = cfg_wdata;
        pc_q = cfg_wdata;
      end
      if (in_valid && !in_stall) execute_opcode(instruction);
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          report("unexpected beat, next_pc", next_pc, 0);
        end else begin
          e = expected_beats.pop_front();
          if (next_pc !== e.pc) report("next_pc", next_pc, e.pc);
          if (write_valid !== e.wv) report("write_valid", write_valid, e.wv);
          if (write_address !== e.addr) report("write_address", write_address, e.addr);
          if (write_data !== e.data) report("write_data", write_data, e.data);
          if (status !== e.st) report("status", status, e.st);
          if (last !== e.lst) report("last", last, e.lst);
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_OPS = 224;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] instruction = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] next_pc;
  logic        write_valid;
  logic [11:0] write_address;
  logic [7:0]  write_data;
  logic [1:0]  status;
  logic        last;
  int          errors;
  int          pending;
  int          cycles = 0;
  logic        steady = 1'b0;

  // shadow of the return stack pointer, to keep returns on written entries
  logic [3:0]  shadow_sp = '0;
  logic [15:0] pushed = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chip8_instruction_execute_core u_top (.*);

  chip8_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= !steady && ($urandom_range(99) < 18);
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(input logic [15:0] w);
    logic ok;
    if (w == 16'h00EE && !pushed[shadow_sp - 4'd1]) w = 16'h00E0;
    if (w == 16'h00EE) shadow_sp = shadow_sp - 4'd1;
    if (w[15:12] == 4'h2) begin
      pushed[shadow_sp] = 1'b1;
      shadow_sp = shadow_sp + 4'd1;
    end
    while (!steady && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    instruction <= w;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_start(input logic [11:0] a);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_opcode();
    logic [15:0] w;
    logic [7:0] misc[10] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h30, 8'h33,
                             8'h55, 8'h65};
    w = 16'($urandom_range(16'hFFFF));
    case (w[15:12])
      4'h0: begin
        case ($urandom_range(9))
          0, 1, 2, 3: w = 16'h00EE;
          4, 5, 6: w = 16'h00E0;
          default: ;
        endcase
      end
      4'h5, 4'h9: if ($urandom_range(3) != 0) w[3:0] = 4'h0;
      4'hE: if ($urandom_range(9) < 7) w[7:0] = $urandom_range(1) ? 8'h9E : 8'hA1;
      4'hF: if ($urandom_range(9) < 8) w[7:0] = misc[$urandom_range(9)];
      default: ;
    endcase
    return w;
  endfunction

  logic [15:0] directed_ops[] = '{
    16'h00E0, 16'h60FF, 16'h6101, 16'h8014, 16'h70FF, 16'h8015, 16'h8107, 16'h8F06,
    16'h800E, 16'h8F1E, 16'h8011, 16'h8012, 16'h8013, 16'h8010, 16'h30FF, 16'h40FF,
    16'h5010, 16'h9010, 16'h5011, 16'h8008, 16'hAFFE, 16'hF033, 16'hFF55, 16'hF01E,
    16'hBFFF, 16'h2300, 16'h00EE, 16'h1ABC, 16'hC123, 16'hD123, 16'hE19E, 16'hE1A1,
    16'hE100, 16'hF007, 16'hF00A, 16'hF015, 16'hF018, 16'hF029, 16'hF030, 16'hF065,
    16'hF0FF, 16'h0123
  };

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_ops[i]) send(directed_ops[i]);
    set_start(12'hFFF);
    send(16'h6080);
    send(16'h3080);
    set_start(12'h000);
    send(16'hA000);
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == 90) steady = 1'b1;
      if (i == 150) steady = 1'b0;
      if (i == 135) set_start(12'($urandom_range(12'hFFF)));
      send(pick_opcode());
    end
    set_start(12'hABC);
    send(16'h1FFE);
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
